/* hdl/assert_macros.svh */
// Assertion macros for the checker file of the border fill block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define IBF_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("border fill check failed");

// Check a property at every rising clock edge, reset included.
`define IBF_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("border fill reset check failed");

`endif

/* hdl/ibf_pkg.sv */
// Types, constants and helper functions of the image border fill block.
`timescale 1ns / 1ps

package ibf_pkg;

    localparam int SIZE_W   = 13;   // width of the size registers
    localparam int BORD_W   = 2;    // width of the border size registers
    localparam int MODE_W   = 2;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 14;   // two's complement border coordinates
    localparam int OFS_W    = 4;    // signed offset -3..+3 around a pixel
    localparam int CMP_W    = 17;   // holds any size up to 65536
    localparam int IDX_W    = 3;
    localparam int OUT_W    = 64;   // pos_x, pos_y, write_value, zero fill

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int DEF_MAX_BORDER = 3;

    localparam logic [MODE_W-1:0] MODE_CONST = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REPL  = 2'd2;

    typedef enum logic [IDX_W-1:0] {
        REG_WIDTH  = 3'd0,
        REG_HEIGHT = 3'd1,
        REG_LEFT   = 3'd2,
        REG_RIGHT  = 3'd3,
        REG_TOP    = 3'd4,
        REG_BOTTOM = 3'd5,
        REG_MODE   = 3'd6,
        REG_FILL   = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [SIZE_W-1:0] image_width;
        logic [SIZE_W-1:0] image_height;
        logic [BORD_W-1:0] border_left;
        logic [BORD_W-1:0] border_right;
        logic [BORD_W-1:0] border_top;
        logic [BORD_W-1:0] border_bottom;
        logic [MODE_W-1:0] pad_mode;
        logic [DATA_W-1:0] fill_value;
    } cfg_t;

    // One edge pixel's worth of border writes.
    typedef struct packed {
        logic [POS_W-1:0]  base_x;
        logic [POS_W-1:0]  base_y;
        logic [BORD_W-1:0] ext_left;
        logic [BORD_W-1:0] ext_right;
        logic [BORD_W-1:0] ext_top;
        logic [BORD_W-1:0] ext_bottom;
        logic [DATA_W-1:0] value;
    } job_t;

    typedef struct packed {
        logic signed [OFS_W-1:0] x;
        logic signed [OFS_W-1:0] y;
    } ofs_t;

    function automatic logic signed [OFS_W-1:0] ofs_of(logic [BORD_W-1:0] b);
        return $signed({{(OFS_W-BORD_W){1'b0}}, b});
    endfunction

    // Advance one place in row-major order over the write rectangle.
    function automatic ofs_t ofs_step(ofs_t p, logic [BORD_W-1:0] dl,
                                      logic [BORD_W-1:0] dr);
        ofs_t q;
        q.x = p.x + 4'sd1;
        q.y = p.y;
        if (q.x > ofs_of(dr))
        begin
            q.x = -ofs_of(dl);
            q.y = p.y + 4'sd1;
        end
        return q;
    endfunction

    // Advance, stepping over the pixel's own place.
    function automatic ofs_t ofs_next(ofs_t p, logic [BORD_W-1:0] dl,
                                      logic [BORD_W-1:0] dr);
        ofs_t q;
        q = ofs_step(p, dl, dr);
        if (q.x == 4'sd0 && q.y == 4'sd0)
        begin
            q = ofs_step(q, dl, dr);
        end
        return q;
    endfunction

endpackage

/* hdl/ibf_queue.sv */
// Two-entry queue of border jobs between the classifier and the write engine.
`timescale 1ns / 1ps

module ibf_queue
    import ibf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_data,
    input  logic pop,
    output job_t pop_data,
    output logic full,
    output logic not_empty
);

    job_t       mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hdl/ibf_front.sv */
// Pixel classifier: tracks the raster position and queues a job for edge pixels.
`timescale 1ns / 1ps

module ibf_front
    import ibf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_BORDER = DEF_MAX_BORDER
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [DATA_W-1:0] s_axis_tdata,
    input  logic              q_full,
    output logic              q_push,
    output job_t              q_data
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    logic [CW-1:0]    col_reg, col_next, col_eff;
    logic [RW-1:0]    row_reg, row_next, row_eff;
    logic [CMP_W-1:0] w_eff, h_eff, col_inc, row_inc;
    logic [BORD_W-1:0] bl, br, bt, bb;
    logic             accept, mode_ok, at_left, at_right, at_top, at_bottom;

    function automatic logic [CMP_W-1:0] clamp_size(logic [SIZE_W-1:0] v,
                                                     logic [CMP_W-1:0] maxv);
        logic [CMP_W-1:0] e;
        e = CMP_W'(v);
        if (e == '0)
        begin
            return CMP_W'(1);
        end
        else if (e > maxv)
        begin
            return maxv;
        end
        return e;
    endfunction

    function automatic logic [BORD_W-1:0] clamp_bord(logic [BORD_W-1:0] v);
        if (v > BORD_W'(MAX_BORDER))
        begin
            return BORD_W'(MAX_BORDER);
        end
        return v;
    endfunction

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign mode_ok       = (cfg.pad_mode == MODE_CONST) || (cfg.pad_mode == MODE_REPL);

    always_comb
    begin
        w_eff = clamp_size(cfg.image_width, CMP_W'(MAX_WIDTH));
        h_eff = clamp_size(cfg.image_height, CMP_W'(MAX_HEIGHT));
        bl    = clamp_bord(cfg.border_left);
        br    = clamp_bord(cfg.border_right);
        bt    = clamp_bord(cfg.border_top);
        bb    = clamp_bord(cfg.border_bottom);

        // restart a counter left outside the region by a size change
        col_eff = (CMP_W'(col_reg) >= w_eff) ? '0 : col_reg;
        row_eff = (CMP_W'(row_reg) >= h_eff) ? '0 : row_reg;
        col_inc = CMP_W'(col_eff) + CMP_W'(1);
        row_inc = CMP_W'(row_eff) + CMP_W'(1);

        at_left   = (col_eff == '0);
        at_right  = (col_inc == w_eff);
        at_top    = (row_eff == '0);
        at_bottom = (row_inc == h_eff);

        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (col_inc >= w_eff)
            begin
                col_next = '0;
                row_next = (row_inc >= h_eff) ? '0 : RW'(row_inc);
            end
            else
            begin
                col_next = CW'(col_inc);
                row_next = row_eff;
            end
        end

        q_data.base_x     = POS_W'(col_eff);
        q_data.base_y     = POS_W'(row_eff);
        q_data.ext_left   = at_left   ? bl : '0;
        q_data.ext_right  = at_right  ? br : '0;
        q_data.ext_top    = at_top    ? bt : '0;
        q_data.ext_bottom = at_bottom ? bb : '0;
        q_data.value      = (cfg.pad_mode == MODE_CONST) ? cfg.fill_value : s_axis_tdata;

        q_push = accept && mode_ok &&
                 ((q_data.ext_left | q_data.ext_right | q_data.ext_top
                   | q_data.ext_bottom) != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

/* hdl/ibf_back.sv */
// Write engine: walks one job's border rectangle and drives the result register.
`timescale 1ns / 1ps

module ibf_back
    import ibf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_not_empty,
    input  job_t             q_data,
    output logic             q_pop,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,
    output logic             m_axis_tlast
);

    job_t              job_reg;
    ofs_t              cur_reg, cur_next, start_ofs;
    logic              busy_reg, busy_next;
    logic              valid_reg, valid_next;
    logic [POS_W-1:0]  pos_x_reg, pos_y_reg;
    logic [DATA_W-1:0] value_reg;
    logic              last_reg;
    logic              out_free, emit, load, is_last;

    assign out_free = !valid_reg || m_axis_tready;
    assign emit     = busy_reg && out_free;
    assign load     = !busy_reg && q_not_empty;
    assign q_pop    = load;

    always_comb
    begin
        start_ofs.x = -ofs_of(q_data.ext_left);
        start_ofs.y = -ofs_of(q_data.ext_top);
        if (start_ofs.x == 4'sd0 && start_ofs.y == 4'sd0)
        begin
            start_ofs = ofs_step(start_ofs, q_data.ext_left, q_data.ext_right);
        end

        cur_next = ofs_next(cur_reg, job_reg.ext_left, job_reg.ext_right);
        is_last  = (cur_next.y > ofs_of(job_reg.ext_bottom));

        busy_next  = busy_reg;
        valid_next = valid_reg && !m_axis_tready;
        if (load)
        begin
            busy_next = 1'b1;
        end
        else if (emit)
        begin
            valid_next = 1'b1;
            busy_next  = !is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            job_reg <= q_data;
            cur_reg <= start_ofs;
        end
        else if (emit)
        begin
            cur_reg   <= cur_next;
            pos_x_reg <= job_reg.base_x + POS_W'(cur_reg.x);
            pos_y_reg <= job_reg.base_y + POS_W'(cur_reg.y);
            value_reg <= job_reg.value;
            last_reg  <= is_last;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {{(OUT_W-2*POS_W-DATA_W){1'b0}}, value_reg, pos_y_reg, pos_x_reg};
    assign m_axis_tlast  = last_reg;

endmodule

/* hdl/image_border_fill.sv */
// Top level of the image border fill block: configuration registers and wiring.
`timescale 1ns / 1ps

// Image border fill, constant or clamp-to-edge padding of one plane.
//
// Input channel s_axis: one transaction per pixel of the valid region, in
// raster order. Output channel m_axis: one transaction per border write,
// tlast high on the final write caused by a pixel. Interior pixels, mode
// codes other than constant and replicate, and zero borders cause no writes.
// Configuration: cfg_wr_en, cfg_index (register 0..7), cfg_data; write only
// while the block is idle.
//
// Throughput: a pixel that causes no writes is taken every cycle while the
// queue is not full. An edge pixel becomes a job in a two-entry queue; the
// write engine emits one write per cycle while the receiver is ready, and
// emits nothing while it loads a job. The pixel's own place is skipped
// without an emit. Input stalls only while the queue is full. A first write
// goes through the queue, the job register and then the result register.
// Reset clears the row and column counters, empties the queue and the
// result register, and loads the configuration reset values. A stalled
// receiver holds the result register; the engine and then the queue back up.

module image_border_fill
    import ibf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_BORDER = DEF_MAX_BORDER
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [DATA_W-1:0] cfg_data,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [DATA_W-1:0] s_axis_tdata,   // [31:0] pixel_value
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_W-1:0]  m_axis_tdata,   // [13:0] pos_x, [27:14] pos_y,
                                              // [59:28] write_value, [63:60] zero
    output logic              m_axis_tlast    // last_write
);

    cfg_t cfg_reg;
    job_t q_in, q_out;
    logic q_push, q_pop, q_full, q_not_empty;

    // Capture register writes; an index is always one of the eight registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width   <= SIZE_W'(1);
            cfg_reg.image_height  <= SIZE_W'(1);
            cfg_reg.border_left   <= '0;
            cfg_reg.border_right  <= '0;
            cfg_reg.border_top    <= '0;
            cfg_reg.border_bottom <= '0;
            cfg_reg.pad_mode      <= '0;
            cfg_reg.fill_value    <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_WIDTH:  cfg_reg.image_width   <= cfg_data[SIZE_W-1:0];
                REG_HEIGHT: cfg_reg.image_height  <= cfg_data[SIZE_W-1:0];
                REG_LEFT:   cfg_reg.border_left   <= cfg_data[BORD_W-1:0];
                REG_RIGHT:  cfg_reg.border_right  <= cfg_data[BORD_W-1:0];
                REG_TOP:    cfg_reg.border_top    <= cfg_data[BORD_W-1:0];
                REG_BOTTOM: cfg_reg.border_bottom <= cfg_data[BORD_W-1:0];
                REG_MODE:   cfg_reg.pad_mode      <= cfg_data[MODE_W-1:0];
                REG_FILL:   cfg_reg.fill_value    <= cfg_data;
                default:    cfg_reg.fill_value    <= cfg_reg.fill_value;
            endcase
        end
    end

    // Classify pixels and advance the raster position.
    ibf_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_BORDER (MAX_BORDER)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (q_in)
    );

    // Decouple classification from the write engine.
    ibf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .full      (q_full),
        .not_empty (q_not_empty)
    );

    // Emit the border writes of each queued job.
    ibf_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_not_empty   (q_not_empty),
        .q_data        (q_out),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

/* hdl/ibf_checker.sv */
// Port-level checks of the image border fill output channel, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ibf_checker
    import ibf_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata,
    input logic             m_axis_tlast
);

    `IBF_ASSERT_ALWAYS(a_reset_empty, !rst_n |-> !m_axis_tvalid)
    `IBF_ASSERT(a_hold_on_stall, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    `IBF_ASSERT(a_pad_zero, m_axis_tvalid |-> m_axis_tdata[OUT_W-1:2*POS_W+DATA_W] == '0)
    `IBF_ASSERT(a_pos_x_floor, m_axis_tvalid |-> !m_axis_tdata[POS_W-1] || m_axis_tdata[POS_W-1:2] == '1)
    `IBF_ASSERT(a_pos_y_floor, m_axis_tvalid |-> !m_axis_tdata[2*POS_W-1] || m_axis_tdata[2*POS_W-1:POS_W+2] == '1)

endmodule

bind image_border_fill ibf_checker u_ibf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

/* tb/sv/tb.sv */
// Self-checking testbench for the image border fill block.
`timescale 1ns / 1ps

// Streams pixels into image_border_fill and checks every border write that it
// emits. A shadow model keeps its own copy of the registers and of the column
// and row counters. For each accepted pixel it works out the border writes
// that the pixel is the nearest valid pixel for. The checker compares each
// write the block hands over with the oldest pending one, field by field.
//
// Stimulus has two parts. A directed table covers:
//  - the reset state
//  - the undefined mode codes
//  - constant fill with 0 and all-ones fill values
//  - replicate mode with the largest borders on a single-pixel plane
//  - zero and oversized sizes
//  - a full small plane with wrap at its end
//  - a size write that leaves a counter out of range
// Random phases follow. Each phase picks a new register setting and then
// streams whole planes, or parts of planes, of random pixels.
// The sender works in bursts. The receiver stalls on a rolling duty pattern
// and holds off once for a long stretch so that the block's queue fills up.

module tb;

    import ibf_pkg::*;

    localparam logic [MODE_W-1:0] MODE_NONE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam int RANDOM_PIXELS = 440;
    localparam int SETTLE_CYCLES = 8;     // engine latency plus margin
    localparam int HOLD_AFTER    = 24;    // pixels sent before the long hold-off
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int PRINT_LIMIT   = 40;

    typedef struct packed {
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [DATA_W-1:0] value;
        logic              last;
    } border_write_t;

    typedef enum logic { ROW_CFG, ROW_PIX } row_kind_t;

    // One row of the directed table: a register write or a pixel. A pixel
    // row may carry its writes typed in (none or a single one).
    typedef struct packed {
        row_kind_t         kind;
        cfg_reg_t          idx;
        logic [DATA_W-1:0] data;
        logic              typed;
        logic              one_write;
        logic [POS_W-1:0]  tx;
        logic [POS_W-1:0]  ty;
        logic [DATA_W-1:0] tv;
    } dir_row_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en     = 1'b0;
    logic [IDX_W-1:0]  cfg_index     = '0;
    logic [DATA_W-1:0] cfg_data      = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [DATA_W-1:0] s_axis_tdata  = '0;    // [31:0] pixel_value
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;          // [13:0] pos_x, [27:14] pos_y,
                                              // [59:28] write_value, [63:60] zero
    logic              m_axis_tlast;          // last_write

    // Shadow registers and counters of the block.
    cfg_t shadow_cfg;
    int   col_ctr;
    int   row_ctr;

    border_write_t pixel_writes[$];      // writes of the pixel just predicted
    border_write_t expected_writes[$];   // writes still owed by the block
    dir_row_t      dir_table[$];

    int pixels_sent    = 0;
    int burst_left     = 0;
    int mismatch_count = 0;

    image_border_fill dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    // Print one mismatch line (capped so a broken block cannot flood the log)
    // and count it.
    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        if (mismatch_count < PRINT_LIMIT)
        begin
            $display("tb: mismatch on %s: got %h, want %h at %0t", what, got, want, $time);
        end
        mismatch_count++;
    endtask

    // A size of zero counts as one, anything above the maximum saturates.
    function automatic int clamp_dim(input logic [SIZE_W-1:0] v, input int lim);
        if (v == '0)
            return 1;
        if (int'(v) > lim)
            return lim;
        return int'(v);
    endfunction

    // Work out the border writes caused by one pixel and advance the counters.
    task automatic predict_border_writes(input logic [DATA_W-1:0] pix);
        int w, h, x0, x1, y0, y1;
        border_write_t bw;
        logic [DATA_W-1:0] val;
        pixel_writes.delete();
        w = clamp_dim(shadow_cfg.image_width, DEF_MAX_WIDTH);
        h = clamp_dim(shadow_cfg.image_height, DEF_MAX_HEIGHT);
        // A size write may have left a counter past the end: restart it.
        if (col_ctr >= w)
            col_ctr = 0;
        if (row_ctr >= h)
            row_ctr = 0;
        if (shadow_cfg.pad_mode == MODE_CONST || shadow_cfg.pad_mode == MODE_REPL)
        begin
            val = (shadow_cfg.pad_mode == MODE_CONST) ? shadow_cfg.fill_value : pix;
            x0 = (col_ctr == 0) ? -int'(shadow_cfg.border_left) : col_ctr;
            x1 = (col_ctr == w - 1) ? col_ctr + int'(shadow_cfg.border_right) : col_ctr;
            y0 = (row_ctr == 0) ? -int'(shadow_cfg.border_top) : row_ctr;
            y1 = (row_ctr == h - 1) ? row_ctr + int'(shadow_cfg.border_bottom) : row_ctr;
            // Row-major order over the rectangle, skipping the pixel itself.
            for (int y = y0; y <= y1; y++)
            begin
                for (int x = x0; x <= x1; x++)
                begin
                    if (!(x == col_ctr && y == row_ctr))
                    begin
                        bw.pos_x = x[POS_W-1:0];
                        bw.pos_y = y[POS_W-1:0];
                        bw.value = val;
                        bw.last  = 1'b0;
                        pixel_writes.push_back(bw);
                    end
                end
            end
            if (pixel_writes.size() != 0)
                pixel_writes[pixel_writes.size() - 1].last = 1'b1;
        end
        // Advance in raster order, wrap at the end of the plane.
        col_ctr++;
        if (col_ctr >= w)
        begin
            col_ctr = 0;
            row_ctr++;
            if (row_ctr >= h)
                row_ctr = 0;
        end
    endtask

    // Drive one register write; call at a rising edge. Leaves cfg_wr_en high
    // so that back-to-back writes follow each other without a gap.
    task automatic write_reg(input cfg_reg_t idx, input logic [DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_WIDTH:  shadow_cfg.image_width   = data[SIZE_W-1:0];
            REG_HEIGHT: shadow_cfg.image_height  = data[SIZE_W-1:0];
            REG_LEFT:   shadow_cfg.border_left   = data[BORD_W-1:0];
            REG_RIGHT:  shadow_cfg.border_right  = data[BORD_W-1:0];
            REG_TOP:    shadow_cfg.border_top    = data[BORD_W-1:0];
            REG_BOTTOM: shadow_cfg.border_bottom = data[BORD_W-1:0];
            REG_MODE:   shadow_cfg.pad_mode      = data[MODE_W-1:0];
            REG_FILL:   shadow_cfg.fill_value    = data;
            default: ;
        endcase
    endtask

    // Drop the input, wait for every owed write, then let the engine settle.
    task automatic quiesce();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_writes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Offer one pixel, inserting a random gap between bursts. The handshake is
    // sampled at the falling edge, where it is stable, and the transaction
    // completes at the next rising edge. Typed rows replace the prediction
    // with the write written into the table (the counters still advance).
    task automatic send_pixel(input logic [DATA_W-1:0] pix, input logic typed,
                              input logic one_write, input border_write_t typed_wr);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                s_axis_tdata  <= $urandom;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        do
            @(negedge clk);
        while (!s_axis_tready);
        predict_border_writes(pix);
        if (typed)
        begin
            if (one_write)
                expected_writes.push_back(typed_wr);
        end
        else
        begin
            foreach (pixel_writes[k])
                expected_writes.push_back(pixel_writes[k]);
        end
        pixels_sent++;
        @(posedge clk);
    endtask

    function automatic dir_row_t cfg_row(input cfg_reg_t idx, input logic [DATA_W-1:0] data);
        dir_row_t row;
        row = '0;
        row.kind = ROW_CFG;
        row.idx  = idx;
        row.data = data;
        return row;
    endfunction

    function automatic dir_row_t pix_row(input logic [DATA_W-1:0] pix);
        dir_row_t row;
        row = '0;
        row.kind = ROW_PIX;
        row.data = pix;
        return row;
    endfunction

    // Pixel with its outcome typed in: no write, or a single final write.
    function automatic dir_row_t typed_pix(input logic [DATA_W-1:0] pix, input logic one_write,
                                           input int x, input int y,
                                           input logic [DATA_W-1:0] val);
        dir_row_t row;
        row = pix_row(pix);
        row.typed     = 1'b1;
        row.one_write = one_write;
        row.tx        = x[POS_W-1:0];
        row.ty        = y[POS_W-1:0];
        row.tv        = val;
        return row;
    endfunction

    // Receiver: a rolling duty pattern, re-rolled over the run (sometimes no stalls
    // at all), plus one long hold-off early in the random part.
    initial
    begin
        int cyc, period, stall_len, hold_left;
        bit hold_used;
        cyc = 0;
        period = 4;
        stall_len = 0;
        hold_left = 0;
        hold_used = 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (!hold_used && pixels_sent >= HOLD_AFTER)
            begin
                hold_used = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (cyc % 64 == 0)
            begin
                period = $urandom_range(2, 8);
                stall_len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, period - 1);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= ((cyc % period) >= stall_len);
            end
        end
    end

    // Output checker: a transaction visible at the falling edge completes at
    // the next rising edge.
    always @(negedge clk)
    begin : write_check
        border_write_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.pos_x = m_axis_tdata[POS_W-1:0];
            got.pos_y = m_axis_tdata[2*POS_W-1:POS_W];
            got.value = m_axis_tdata[2*POS_W+DATA_W-1:2*POS_W];
            got.last  = m_axis_tlast;
            if (expected_writes.size() == 0)
            begin
                report_mismatch("write with none pending",
                                DATA_W'({got.pos_y, got.pos_x}), '0);
            end
            else
            begin
                want = expected_writes.pop_front();
                if (got.pos_x !== want.pos_x)
                    report_mismatch("pos_x", DATA_W'(got.pos_x), DATA_W'(want.pos_x));
                if (got.pos_y !== want.pos_y)
                    report_mismatch("pos_y", DATA_W'(got.pos_y), DATA_W'(want.pos_y));
                if (got.value !== want.value)
                    report_mismatch("write_value", got.value, want.value);
                if (got.last !== want.last)
                    report_mismatch("last_write", DATA_W'(got.last), DATA_W'(want.last));
            end
        end
    end

    // Main sequence: reset, directed table, random phases, drain, verdict.
    initial
    begin
        int w, h, n_pix, pick, k;
        logic [DATA_W-1:0] pix;
        logic [SIZE_W-1:0] w_reg, h_reg;
        logic [MODE_W-1:0] mode;
        logic [DATA_W-1:0] fill;
        bit cfg_open;
        border_write_t typed_wr;

        rst_n <= 1'b0;
        shadow_cfg = '0;
        shadow_cfg.image_width  = SIZE_W'(1);
        shadow_cfg.image_height = SIZE_W'(1);
        col_ctr = 0;
        row_ctr = 0;
        cfg_open = 1'b0;

        dir_table = '{
            // Reset state: mode undefined, nothing written.
            typed_pix(32'hFFFF_FFFF, 1'b0, 0, 0, '0),
            // Single-pixel plane, one left column in constant fill.
            cfg_row(REG_LEFT, 1),
            cfg_row(REG_MODE, MODE_CONST),
            cfg_row(REG_FILL, 32'hA5A5_A5A5),
            typed_pix(32'h1234_5678, 1'b1, -1, 0, 32'hA5A5_A5A5),
            // Unused mode code behaves as undefined.
            cfg_row(REG_MODE, MODE_UNUSED),
            typed_pix(32'h0000_0000, 1'b0, 0, 0, '0),
            // Replicate with every border at its maximum: the largest burst.
            // Zero sizes count as one.
            cfg_row(REG_MODE, MODE_REPL),
            cfg_row(REG_LEFT, 3),
            cfg_row(REG_RIGHT, 3),
            cfg_row(REG_TOP, 3),
            cfg_row(REG_BOTTOM, 3),
            cfg_row(REG_WIDTH, 0),
            cfg_row(REG_HEIGHT, 0),
            pix_row(32'hFFFF_FFFF),
            pix_row(32'h0000_0000),
            // No border at all.
            cfg_row(REG_LEFT, 0),
            cfg_row(REG_RIGHT, 0),
            cfg_row(REG_TOP, 0),
            cfg_row(REG_BOTTOM, 0),
            typed_pix(32'h5A5A_5A5A, 1'b0, 0, 0, '0),
            // Full 3x3 plane with uneven borders, wrap, then one more pixel.
            cfg_row(REG_WIDTH, 3),
            cfg_row(REG_HEIGHT, 3),
            cfg_row(REG_LEFT, 2),
            cfg_row(REG_RIGHT, 1),
            cfg_row(REG_TOP, 1),
            cfg_row(REG_BOTTOM, 2),
            cfg_row(REG_FILL, 32'hFFFF_FFFF),
            cfg_row(REG_MODE, MODE_CONST),
            pix_row(32'h0000_0001),
            pix_row(32'h8000_0000),
            pix_row(32'h0000_0002),
            pix_row(32'h4000_0000),
            pix_row(32'hDEAD_BEEF),
            pix_row(32'h0000_0004),
            pix_row(32'h2000_0000),
            pix_row(32'h0000_0008),
            pix_row(32'h1000_0000),
            pix_row(32'h7FFF_FFFF),
            // Oversized width saturates; top band of a wide plane.
            cfg_row(REG_WIDTH, 8191),
            cfg_row(REG_HEIGHT, 2),
            cfg_row(REG_MODE, MODE_REPL),
            pix_row(32'hCAFE_F00D),
            // Shrink the width under the column counter: it restarts at 0.
            cfg_row(REG_WIDTH, 1),
            pix_row(32'h0F0F_0F0F),
            // Constant fill of zero, then undefined mode again.
            cfg_row(REG_FILL, 0),
            cfg_row(REG_MODE, MODE_CONST),
            pix_row(32'hF0F0_F0F0),
            cfg_row(REG_MODE, MODE_NONE),
            typed_pix(32'h3C3C_3C3C, 1'b0, 0, 0, '0)
        };

        // Hold reset, then release it once for good.
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table; close register writes before each pixel.
        foreach (dir_table[i])
        begin
            if (dir_table[i].kind == ROW_CFG)
            begin
                if (!cfg_open)
                begin
                    quiesce();
                    cfg_open = 1'b1;
                end
                write_reg(dir_table[i].idx, dir_table[i].data);
            end
            else
            begin
                if (cfg_open)
                begin
                    cfg_wr_en <= 1'b0;
                    cfg_open = 1'b0;
                end
                typed_wr.pos_x = dir_table[i].tx;
                typed_wr.pos_y = dir_table[i].ty;
                typed_wr.value = dir_table[i].tv;
                typed_wr.last  = 1'b1;
                send_pixel(dir_table[i].data, dir_table[i].typed,
                           dir_table[i].one_write, typed_wr);
            end
        end

        // Random phases: new setting, then a run of pixels. The first phase
        // always produces heavy writes so the long hold-off backs up the block.
        n_pix = pixels_sent + RANDOM_PIXELS;
        k = 0;
        while (pixels_sent < n_pix)
        begin
            pick = $urandom_range(0, 9);
            if (k == 0 || pick >= 2)
            begin
                w_reg = ($urandom_range(0, 15) == 0) ? 13'd0 : 13'($urandom_range(1, 6));
                h_reg = ($urandom_range(0, 15) == 0) ? 13'd0 : 13'($urandom_range(1, 6));
            end
            else if (pick == 0)
            begin
                // Wide plane: oversized, exact maximum or just below it.
                case ($urandom_range(0, 2))
                    0:       w_reg = 13'd8191;
                    1:       w_reg = 13'd4096;
                    default: w_reg = 13'($urandom_range(4000, 4095));
                endcase
                h_reg = 13'($urandom_range(1, 2));
            end
            else
            begin
                // Tall narrow plane: side bands on every pixel.
                w_reg = 13'($urandom_range(1, 2));
                h_reg = ($urandom_range(0, 1) == 0) ? 13'd4096 : 13'd8191;
            end
            case ($urandom_range(0, 9))
                0:       mode = MODE_NONE;
                1:       mode = MODE_UNUSED;
                2, 3, 4, 5: mode = MODE_CONST;
                default: mode = MODE_REPL;
            endcase
            case ($urandom_range(0, 5))
                0:       fill = '0;
                1:       fill = '1;
                default: fill = $urandom;
            endcase
            if (k == 0)
            begin
                w_reg = 13'($urandom_range(2, 5));
                h_reg = 13'($urandom_range(2, 4));
                mode  = MODE_REPL;
            end

            quiesce();
            write_reg(REG_WIDTH, 32'(w_reg));
            write_reg(REG_HEIGHT, 32'(h_reg));
            if (k == 0)
            begin
                write_reg(REG_LEFT, 3);
                write_reg(REG_RIGHT, 3);
                write_reg(REG_TOP, 3);
                write_reg(REG_BOTTOM, 3);
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                write_reg(REG_LEFT, 0);
                write_reg(REG_RIGHT, 0);
                write_reg(REG_TOP, 0);
                write_reg(REG_BOTTOM, 0);
            end
            else
            begin
                write_reg(REG_LEFT, $urandom_range(0, 3));
                write_reg(REG_RIGHT, $urandom_range(0, 3));
                write_reg(REG_TOP, $urandom_range(0, 3));
                write_reg(REG_BOTTOM, $urandom_range(0, 3));
            end
            write_reg(REG_MODE, 32'(mode));
            write_reg(REG_FILL, fill);
            cfg_wr_en <= 1'b0;

            // Mostly whole planes, sometimes a part of one.
            w = clamp_dim(w_reg, DEF_MAX_WIDTH);
            h = clamp_dim(h_reg, DEF_MAX_HEIGHT);
            if (w * h > 40)
                pick = $urandom_range(20, 40);
            else if (k != 0 && $urandom_range(0, 3) == 0)
                pick = $urandom_range(1, 20);
            else
                pick = w * h * $urandom_range(1, 3);
            if (k == 0 && pick < 3 * w * h)
                pick = 3 * w * h;
            if (pick > n_pix - pixels_sent)
                pick = n_pix - pixels_sent;

            typed_wr = '0;
            repeat (pick)
            begin
                case ($urandom_range(0, 7))
                    0:       pix = '0;
                    1:       pix = '1;
                    default: pix = $urandom;
                endcase
                send_pixel(pix, 1'b0, 1'b0, typed_wr);
            end
            k++;
        end

        // Drain: wait for every owed write, then let the engine settle and watch
        // for strays.
        s_axis_tvalid <= 1'b0;
        for (k = 0; k < DRAIN_LIMIT && expected_writes.size() != 0; k++)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_writes.size() != 0)
            report_mismatch("writes never delivered", expected_writes.size(), '0);

        if (mismatch_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
